FILE: rtl/core/c2dv_pkg.sv
package c2dv_pkg;

  localparam int PIX_W  = 16;
  localparam int PROD_W = 32;
  localparam int SUM_W  = 38;
  localparam int ROW_W  = 17;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] REG_FILTER_SIZE = 2'd0;
  localparam logic [CFG_AW-1:0] REG_OUT_WIDTH   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_OUT_ROWS    = 2'd2;

  localparam logic ACT_LOAD_COEF = 1'b0;
  localparam logic ACT_PIXEL     = 1'b1;

  typedef struct packed {
    logic                    action;
    logic [5:0]              coef_index;
    logic signed [PIX_W-1:0] value;
  } c2dv_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [15:0]             out_row;
    logic [7:0]              out_col;
    logic                    frame_last;
  } c2dv_out_t;

  typedef struct packed {
    logic [15:0] out_row;
    logic [7:0]  out_col;
    logic        frame_last;
  } c2dv_meta_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } c2dv_tap_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAPS,
    ST_FLUSH,
    ST_HOLD
  } c2dv_state_t;

endpackage

FILE: rtl/core/c2dv_line_mem.sv
module c2dv_line_mem #(
  parameter int DEPTH = 2104,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic signed [c2dv_pkg::PIX_W-1:0] wdata,
  input  logic [AW-1:0]                    raddr,
  output logic signed [c2dv_pkg::PIX_W-1:0] rdata
);
  import c2dv_pkg::*;

  logic signed [PIX_W-1:0] mem [DEPTH];
  logic signed [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/c2dv_coef_mem.sv
module c2dv_coef_mem #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic signed [c2dv_pkg::PIX_W-1:0] wdata,
  input  logic [AW-1:0]                    raddr,
  output logic signed [c2dv_pkg::PIX_W-1:0] rdata
);
  import c2dv_pkg::*;

  logic signed [PIX_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]        vld_r;
  logic signed [PIX_W-1:0] rdata_r;
  logic                    rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rd_vld_r <= vld_r[raddr];
    end
  end

  assign rdata = rd_vld_r ? rdata_r : '0;

endmodule

FILE: rtl/core/c2dv_mac.sv
module c2dv_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  c2dv_pkg::c2dv_tap_t               tap_i,
  input  logic signed [c2dv_pkg::PIX_W-1:0] pix_i,
  input  logic signed [c2dv_pkg::PIX_W-1:0] coef_i,
  output logic signed [c2dv_pkg::SUM_W-1:0] sum_o,
  output logic                              done_o
);
  import c2dv_pkg::*;

  c2dv_tap_t                s1_r;
  c2dv_tap_t                s2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  acc_r;
  logic                     done_r;

  // s1 lines up with the memory read data, s2 with the product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= '0;
      s2_r   <= '0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= tap_i;
      s2_r   <= s1_r;
      done_r <= s2_r.vld && s2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= pix_i * coef_i;
    if (s2_r.vld) begin
      acc_r <= s2_r.first ? SUM_W'(prod_r) : acc_r + SUM_W'(prod_r);
    end
  end

  assign sum_o  = acc_r;
  assign done_o = done_r;

endmodule

FILE: rtl/core/c2dv_ctrl.sv
module c2dv_ctrl #(
  parameter int MAX_FILTER = 8,
  parameter int MAX_WIDTH  = 256,
  localparam int LDEPTH = MAX_FILTER * (MAX_WIDTH + MAX_FILTER - 1),
  localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1,
  localparam int CDEPTH = MAX_FILTER * MAX_FILTER,
  localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [c2dv_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [c2dv_pkg::CFG_DW-1:0]       cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  c2dv_pkg::c2dv_in_t                in_data,
  input  logic                              out_free_i,
  output logic                              line_we_o,
  output logic [LAW-1:0]                    line_waddr_o,
  output logic [LAW-1:0]                    line_raddr_o,
  output logic                              coef_we_o,
  output logic [CAW-1:0]                    coef_waddr_o,
  output logic [CAW-1:0]                    coef_raddr_o,
  output c2dv_pkg::c2dv_tap_t               tap_o,
  input  logic                              mac_done_i,
  output logic                              ld_o,
  output c2dv_pkg::c2dv_meta_t              meta_o
);
  import c2dv_pkg::*;

  localparam int STRIDE = MAX_WIDTH + MAX_FILTER - 1;
  localparam int FW     = $clog2(MAX_FILTER + 1);
  localparam int SW     = (MAX_FILTER > 1) ? $clog2(MAX_FILTER) : 1;
  localparam int CW     = $clog2(MAX_WIDTH + MAX_FILTER);
  localparam int WW     = $clog2(MAX_WIDTH + 1);

  c2dv_state_t state_r, state_nxt;

  logic [3:0]       fs_raw_r;
  logic [8:0]       ow_raw_r;
  logic [15:0]      or_raw_r;

  logic [FW-1:0]    f_eff, f_m1;
  logic [WW-1:0]    w_eff;
  logic [15:0]      r_eff;
  logic [CW-1:0]    in_w_m1;
  logic [ROW_W-1:0] in_h_m1;

  logic [CW-1:0]    in_col_r;
  logic [ROW_W-1:0] in_row_r;
  logic [SW-1:0]    wr_slot_r;
  logic [LAW-1:0]   wr_base_r;

  logic [CW-1:0]    ocol_r;
  logic [LAW-1:0]   base_r;
  logic [SW-1:0]    slot_r, k_r, l_r;
  logic [CAW-1:0]   cidx_r;
  c2dv_meta_t       meta_r;

  logic             in_acc, pix_acc, cfg_hit, win;
  logic             wr_slot_last, slot_last, l_last, k_last;
  logic [CW-1:0]    ocol_nxt;
  logic [ROW_W-1:0] orow_nxt;
  logic [SW-1:0]    start_slot;
  logic [LAW-1:0]   start_base;

  // clamp the raw registers to their legal ranges
  always_comb begin
    if (fs_raw_r == '0) begin
      f_eff = FW'(1);
    end else if (int'(fs_raw_r) > MAX_FILTER) begin
      f_eff = FW'(MAX_FILTER);
    end else begin
      f_eff = FW'(fs_raw_r);
    end
    if (ow_raw_r == '0) begin
      w_eff = WW'(1);
    end else if (int'(ow_raw_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(ow_raw_r);
    end
    r_eff = (or_raw_r == '0) ? 16'd1 : or_raw_r;
  end

  assign f_m1    = f_eff - FW'(1);
  assign in_w_m1 = CW'(w_eff) + CW'(f_m1) - CW'(1);
  assign in_h_m1 = ROW_W'(r_eff) + ROW_W'(f_m1) - ROW_W'(1);

  assign in_acc  = in_valid && in_ready;
  assign pix_acc = in_acc && (in_data.action == ACT_PIXEL);
  assign cfg_hit = cfg_we && (cfg_addr == REG_FILTER_SIZE || cfg_addr == REG_OUT_WIDTH ||
                              cfg_addr == REG_OUT_ROWS);

  assign win      = (in_row_r >= ROW_W'(f_m1)) && (in_col_r >= CW'(f_m1));
  assign ocol_nxt = in_col_r - CW'(f_m1);
  assign orow_nxt = in_row_r - ROW_W'(f_m1);

  // line slots rotate modulo F; the window's top row sits one slot past the write slot
  assign wr_slot_last = (FW'(wr_slot_r) == f_m1);
  assign start_slot   = wr_slot_last ? '0 : wr_slot_r + SW'(1);
  assign start_base   = wr_slot_last ? '0 : wr_base_r + LAW'(STRIDE);

  assign slot_last = (FW'(slot_r) == f_m1);
  assign l_last    = (FW'(l_r) == f_m1);
  assign k_last    = (FW'(k_r) == f_m1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (pix_acc && win) state_nxt = ST_TAPS;
      ST_TAPS:  if (l_last && k_last) state_nxt = ST_FLUSH;
      ST_FLUSH: if (mac_done_i) state_nxt = out_free_i ? ST_IDLE : ST_HOLD;
      ST_HOLD:  if (out_free_i) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    tap_o     = '0;
    ld_o      = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_TAPS: begin
        tap_o.vld   = 1'b1;
        tap_o.first = (k_r == '0) && (l_r == '0);
        tap_o.last  = l_last && k_last;
      end
      ST_FLUSH: ld_o = mac_done_i && out_free_i;
      ST_HOLD:  ld_o = out_free_i;
      default:  in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fs_raw_r  <= 4'd3;
      ow_raw_r  <= 9'd256;
      or_raw_r  <= 16'd256;
      in_col_r  <= '0;
      in_row_r  <= '0;
      wr_slot_r <= '0;
      wr_base_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_FILTER_SIZE: fs_raw_r <= cfg_wdata[3:0];
          REG_OUT_WIDTH:   ow_raw_r <= cfg_wdata[8:0];
          REG_OUT_ROWS:    or_raw_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      // any register write restarts the frame
      if (cfg_hit) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        wr_slot_r <= '0;
        wr_base_r <= '0;
      end else if (pix_acc) begin
        if (in_col_r == in_w_m1) begin
          in_col_r <= '0;
          if (in_row_r == in_h_m1) begin
            in_row_r  <= '0;
            wr_slot_r <= '0;
            wr_base_r <= '0;
          end else begin
            in_row_r  <= in_row_r + ROW_W'(1);
            wr_slot_r <= start_slot;
            wr_base_r <= start_base;
          end
        end else begin
          in_col_r <= in_col_r + CW'(1);
        end
      end
    end
  end

  // tap walk: row by row over the window, coefficient index runs k*F+l
  always_ff @(posedge clk) begin
    if (pix_acc && win) begin
      ocol_r             <= ocol_nxt;
      slot_r             <= start_slot;
      base_r             <= start_base;
      k_r                <= '0;
      l_r                <= '0;
      cidx_r             <= '0;
      meta_r.out_row     <= 16'(orow_nxt);
      meta_r.out_col     <= 8'(ocol_nxt);
      meta_r.frame_last  <= (in_row_r == in_h_m1) && (in_col_r == in_w_m1);
    end else if (state_r == ST_TAPS) begin
      cidx_r <= cidx_r + CAW'(1);
      if (l_last) begin
        l_r <= '0;
        k_r <= k_r + SW'(1);
        if (slot_last) begin
          slot_r <= '0;
          base_r <= '0;
        end else begin
          slot_r <= slot_r + SW'(1);
          base_r <= base_r + LAW'(STRIDE);
        end
      end else begin
        l_r <= l_r + SW'(1);
      end
    end
  end

  assign line_we_o    = pix_acc;
  assign line_waddr_o = wr_base_r + LAW'(in_col_r);
  assign line_raddr_o = base_r + LAW'(ocol_r) + LAW'(l_r);
  assign coef_we_o    = in_acc && (in_data.action == ACT_LOAD_COEF) &&
                        (int'(in_data.coef_index) < CDEPTH);
  assign coef_waddr_o = CAW'(in_data.coef_index);
  assign coef_raddr_o = cidx_r;
  assign meta_o       = meta_r;

endmodule

FILE: rtl/core/conv2d_valid_fxf.sv
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready  | in_data (action, coef_index, value)
// out     | out | out_valid / out_ready| out_data (sum, out_row, out_col, frame_last)
// cfg     | in  | cfg_we               | cfg_addr, cfg_wdata
//
// a coefficient load or a pixel that completes no window leaves the input ready
// a pixel that completes a window holds the input off while one shared
// multiply-accumulate walks the taps, one line store and one coefficient read per cycle
// out_data sits in an output register; a new item is taken while it waits
// the output stall only holds the block once a second window sum is ready
// reset is synchronous; coefficients read as zero until loaded, no clearing pass
module conv2d_valid_fxf #(
  parameter int MAX_FILTER = 8,
  parameter int MAX_WIDTH  = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [c2dv_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [c2dv_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  c2dv_pkg::c2dv_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output c2dv_pkg::c2dv_out_t         out_data
);
  import c2dv_pkg::*;

  localparam int LDEPTH = MAX_FILTER * (MAX_WIDTH + MAX_FILTER - 1);
  localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int CDEPTH = MAX_FILTER * MAX_FILTER;
  localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;

  logic                    line_we, coef_we, ld, mac_done, out_free;
  logic [LAW-1:0]          line_waddr, line_raddr;
  logic [CAW-1:0]          coef_waddr, coef_raddr;
  logic signed [PIX_W-1:0] pix_rd, coef_rd;
  logic signed [SUM_W-1:0] mac_sum;
  c2dv_tap_t               tap;
  c2dv_meta_t              meta;

  logic                    out_valid_r;
  c2dv_out_t               out_data_r;

  assign out_free = !out_valid_r || out_ready;

  c2dv_ctrl #(
    .MAX_FILTER (MAX_FILTER),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_free_i   (out_free),
    .line_we_o    (line_we),
    .line_waddr_o (line_waddr),
    .line_raddr_o (line_raddr),
    .coef_we_o    (coef_we),
    .coef_waddr_o (coef_waddr),
    .coef_raddr_o (coef_raddr),
    .tap_o        (tap),
    .mac_done_i   (mac_done),
    .ld_o         (ld),
    .meta_o       (meta)
  );

  c2dv_line_mem #(
    .DEPTH (LDEPTH)
  ) u_line_mem (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (in_data.value),
    .raddr (line_raddr),
    .rdata (pix_rd)
  );

  c2dv_coef_mem #(
    .DEPTH (CDEPTH)
  ) u_coef_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (in_data.value),
    .raddr (coef_raddr),
    .rdata (coef_rd)
  );

  c2dv_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .tap_i  (tap),
    .pix_i  (pix_rd),
    .coef_i (coef_rd),
    .sum_o  (mac_sum),
    .done_o (mac_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_data_r.sum        <= mac_sum;
      out_data_r.out_row    <= meta.out_row;
      out_data_r.out_col    <= meta.out_col;
      out_data_r.frame_last <= meta.frame_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/c2dv_check.sv
module c2dv_check (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input c2dv_pkg::c2dv_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input c2dv_pkg::c2dv_out_t out_data
);
  import c2dv_pkg::*;

  // a waiting result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // a coefficient load never blocks the input
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.action == ACT_LOAD_COEF |=> in_ready)
    else $error("input blocked after a coefficient load");

  // a new result only appears after a busy stretch of the input side
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a window computation");

  // the multiply-accumulate pipe keeps a new result from rising at once after a pixel item
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.action == ACT_PIXEL |=> !$rose(out_valid))
    else $error("result appeared too early after a pixel");

endmodule

bind conv2d_valid_fxf c2dv_check u_check (.*);
